/* design/plcbl_pkg.sv */
// shared types, sizes and codes for the plc bit logic executor
package plcbl_pkg;

    // sizes of the bit space
    localparam int INPUT_COUNT = 16;
    localparam int OUTPUT_COUNT = 16;
    localparam int RELAY_COUNT = 200;
    localparam int STACK_DEPTH = 32;

    // field widths of the words
    localparam int OPCODE_W = 5;
    localparam int ADDR_W = 16;
    localparam int IMAGE_W = 16;
    localparam int ADV_W = 2;
    localparam int ERR_W = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // bit space layout
    localparam int OUT_BASE = INPUT_COUNT;
    localparam int RELAY_BASE = INPUT_COUNT + OUTPUT_COUNT;
    localparam int SPACE_END = INPUT_COUNT + OUTPUT_COUNT + RELAY_COUNT;

    // index widths, kept at least one bit
    localparam int IN_IDX_W = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int OUT_IDX_W = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
    localparam int RLY_IDX_W = $clog2(RELAY_COUNT);
    localparam int IDX_W_A = (IN_IDX_W > OUT_IDX_W) ? IN_IDX_W : OUT_IDX_W;
    localparam int IDX_W = (IDX_W_A > RLY_IDX_W) ? IDX_W_A : RLY_IDX_W;
    localparam int STK_IDX_W = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    // widened views of the images
    localparam int IN_EXT_W = (INPUT_COUNT > IMAGE_W) ? INPUT_COUNT : IMAGE_W;
    localparam int OUT_EXT_W = (OUTPUT_COUNT > IMAGE_W) ? OUTPUT_COUNT : IMAGE_W;

    // edge code: previous-scan bit in bit 0, current bit in bit 1
    localparam logic [1:0] EDGE_PREV = 2'b01;
    localparam logic [1:0] EDGE_CUR = 2'b10;

    // advance values
    localparam logic [ADV_W-1:0] ADV_RESTART = 2'd0;
    localparam logic [ADV_W-1:0] ADV_SHORT = 2'd1;
    localparam logic [ADV_W-1:0] ADV_LONG = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_NOP  = 5'd0,
        OP_END  = 5'd1,
        OP_LD   = 5'd2,
        OP_LDI  = 5'd3,
        OP_OUT  = 5'd4,
        OP_AND  = 5'd5,
        OP_ANI  = 5'd6,
        OP_OR   = 5'd7,
        OP_ORI  = 5'd8,
        OP_LDP  = 5'd9,
        OP_LDF  = 5'd10,
        OP_ANDP = 5'd11,
        OP_ANDF = 5'd12,
        OP_ORP  = 5'd13,
        OP_ORF  = 5'd14,
        OP_MPS  = 5'd15,
        OP_MRD  = 5'd16,
        OP_MPP  = 5'd17,
        OP_SET  = 5'd18,
        OP_RST  = 5'd19,
        OP_INV  = 5'd20
    } opcode_t;

    // what the back end does with a word
    typedef enum logic [3:0] {
        K_NOP, K_END, K_LOAD, K_AND, K_OR, K_OUT, K_SET, K_RST,
        K_MPS, K_MRD, K_MPP, K_INV
    } kind_t;

    // how the addressed bit becomes an operand
    typedef enum logic [1:0] {
        SRC_PLAIN, SRC_NOT, SRC_RISE, SRC_FALL
    } src_t;

    // which image the address falls in
    typedef enum logic [1:0] {
        REG_INPUT, REG_OUTPUT, REG_RELAY, REG_NONE
    } region_t;

    // classified instruction word
    typedef struct packed {
        kind_t                 kind;
        src_t                  src;
        region_t               region;
        logic [IDX_W-1:0]      index;
        logic [ADV_W-1:0]      advance;
        logic [IMAGE_W-1:0]    input_image;
    } item_t;

    // queue status towards the front and back
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

endpackage

/* design/plc_bit_logic_executor.sv */
// top level of the plc bit logic executor: front end, queue and back end
//
// Executes one PLC bit instruction per word at a sustained rate of one word
// per clock while the result side is not stalled. A word accepted at a
// clock edge is written into the two-word queue; from the queue head the
// execute stage runs it and loads its result into the output register once
// that register is free or draining. The execute stage reads the addressed
// bit, combines it with the accumulator and writes the output, relay and
// stack registers at the same clock edge as the result register. While a
// result waits, the queue takes up to two more words before the input
// stalls. All state sits in flip-flops; control and machine state is
// cleared by reset at once, with no clearing pass, but the queue entries
// and result payload are not reset. Addresses past the relays read as zero.
module plc_bit_logic_executor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode [4:0], bit_address [20:5], input_image [36:21], zero fill above
    input  logic [plcbl_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // output_image [15:0], accumulator [16], advance [18:17],
    // restart_scan [19], error_code [21:20], zero fill above
    output logic [plcbl_pkg::M_DATA_W-1:0]  m_tdata
);
    import plcbl_pkg::*;

    item_t         front_item;
    item_t         head_item;
    queue_status_t q_status;
    logic          push;
    logic          pop;

    // classify incoming words
    plcbl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .item     (front_item)
    );

    // decouple front and back
    plcbl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head_item),
        .status    (q_status)
    );

    // execute and hold the result
    plcbl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_item),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a restarting result always carries advance zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[IMAGE_W+1+ADV_W]) |-> (m_tdata[IMAGE_W+1 +: ADV_W] == ADV_RESTART))
        else $error("restart without zero advance");

    // any stack error forces a restart
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[IMAGE_W+2+ADV_W +: ERR_W] != ERR_NONE))
            |-> m_tdata[IMAGE_W+1+ADV_W])
        else $error("stack error without restart");

    // the back end never drains an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_status.not_empty)
        else $error("pop from empty queue");

    // a word taken while the queue is empty shows in the queue the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_status.not_empty) |=> q_status.not_empty)
        else $error("accepted word lost in queue");

endmodule

/* design/plcbl_front.sv */
// front end: accepts instruction words and classifies opcode and address
module plcbl_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode [4:0], bit_address [20:5], input_image [36:21], zero fill above
    input  logic [plcbl_pkg::S_DATA_W-1:0]  s_tdata,
    input  plcbl_pkg::queue_status_t        q_status,
    output logic                            push,
    output plcbl_pkg::item_t                item
);
    import plcbl_pkg::*;

    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   bit_address;
    logic [ADDR_W-1:0]   offset;
    kind_t               item_kind;
    src_t                item_src;
    logic [ADV_W-1:0]    item_adv;
    region_t             item_region;

    assign opcode      = s_tdata[OPCODE_W-1:0];
    assign bit_address = s_tdata[OPCODE_W +: ADDR_W];

    // handshake: take a word whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // opcode classification
    always_comb begin
        item_kind = K_NOP;
        item_src  = SRC_PLAIN;
        item_adv  = ADV_LONG;
        unique case (opcode)
            OP_END:  begin item_kind = K_END;  item_adv = ADV_RESTART; end
            OP_LD:   item_kind = K_LOAD;
            OP_LDI:  begin item_kind = K_LOAD; item_src = SRC_NOT;  end
            OP_LDP:  begin item_kind = K_LOAD; item_src = SRC_RISE; end
            OP_LDF:  begin item_kind = K_LOAD; item_src = SRC_FALL; end
            OP_AND:  item_kind = K_AND;
            OP_ANI:  begin item_kind = K_AND;  item_src = SRC_NOT;  end
            OP_ANDP: begin item_kind = K_AND;  item_src = SRC_RISE; end
            OP_ANDF: begin item_kind = K_AND;  item_src = SRC_FALL; end
            OP_OR:   item_kind = K_OR;
            OP_ORI:  begin item_kind = K_OR;   item_src = SRC_NOT;  end
            OP_ORP:  begin item_kind = K_OR;   item_src = SRC_RISE; end
            OP_ORF:  begin item_kind = K_OR;   item_src = SRC_FALL; end
            OP_OUT:  item_kind = K_OUT;
            OP_SET:  item_kind = K_SET;
            OP_RST:  item_kind = K_RST;
            OP_MPS:  begin item_kind = K_MPS;  item_adv = ADV_SHORT; end
            OP_MRD:  begin item_kind = K_MRD;  item_adv = ADV_SHORT; end
            OP_MPP:  begin item_kind = K_MPP;  item_adv = ADV_SHORT; end
            OP_INV:  begin item_kind = K_INV;  item_adv = ADV_SHORT; end
            default: begin item_kind = K_NOP;  item_adv = ADV_SHORT; end
        endcase
    end

    // address region and offset within it
    always_comb begin
        priority if (bit_address < ADDR_W'(OUT_BASE)) begin
            item_region = REG_INPUT;
            offset      = bit_address;
        end else if (bit_address < ADDR_W'(RELAY_BASE)) begin
            item_region = REG_OUTPUT;
            offset      = bit_address - ADDR_W'(OUT_BASE);
        end else if (bit_address < ADDR_W'(SPACE_END)) begin
            item_region = REG_RELAY;
            offset      = bit_address - ADDR_W'(RELAY_BASE);
        end else begin
            item_region = REG_NONE;
            offset      = '0;
        end
    end

    // classified word, fields in declaration order
    assign item = {item_kind, item_src, item_region, offset[IDX_W-1:0], item_adv,
                   s_tdata[OPCODE_W + ADDR_W +: IMAGE_W]};

endmodule

/* design/plcbl_queue.sv */
// two-word queue of classified instructions between front and back
module plcbl_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  plcbl_pkg::item_t           push_item,
    input  logic                       pop,
    output plcbl_pkg::item_t           head,
    output plcbl_pkg::queue_status_t   status
);
    import plcbl_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != 2'd0);
    assign status.full      = (count_reg == 2'd2);

endmodule

/* design/plcbl_back.sv */
// back end: executes instructions on the bit images and holds the result word
module plcbl_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  plcbl_pkg::item_t                head,
    input  plcbl_pkg::queue_status_t        q_status,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // output_image [15:0], accumulator [16], advance [18:17],
    // restart_scan [19], error_code [21:20], zero fill above
    output logic [plcbl_pkg::M_DATA_W-1:0]  m_tdata
);
    import plcbl_pkg::*;

    // machine state
    logic                    acc_reg, acc_next;
    logic [STACK_DEPTH-1:0]  stack_reg, stack_next;
    logic [SP_W-1:0]         sp_reg, sp_next;
    logic [OUTPUT_COUNT-1:0] out_bits_reg, out_bits_next;
    logic [RELAY_COUNT-1:0]  relay_reg, relay_next;
    logic [INPUT_COUNT-1:0]  prev_in_reg, prev_in_next;
    logic [OUTPUT_COUNT-1:0] prev_out_reg, prev_out_next;
    logic [RELAY_COUNT-1:0]  prev_relay_reg, prev_relay_next;

    // result word
    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg, m_data_next;

    logic [IN_EXT_W-1:0]     in_ext;
    logic [INPUT_COUNT-1:0]  cur_in;
    logic [OUT_EXT_W-1:0]    out_ext;
    logic                    cur_bit, prev_bit;
    logic [1:0]              edge_code;
    logic                    operand;
    logic                    wr_en, wr_val;
    logic [SP_W-1:0]         sp_dec;
    logic [ADV_W-1:0]        adv;
    logic                    restart;
    logic [ERR_W-1:0]        err;

    // execute when a word waits and the result slot is free or draining
    assign pop = q_status.not_empty && (!m_valid_reg || m_tready);

    // inputs of this word, cut to the input count
    assign in_ext = IN_EXT_W'(head.input_image);
    assign cur_in = in_ext[INPUT_COUNT-1:0];

    // addressed bit, current and previous scan
    always_comb begin
        unique case (head.region)
            REG_INPUT: begin
                cur_bit  = cur_in[head.index[IN_IDX_W-1:0]];
                prev_bit = prev_in_reg[head.index[IN_IDX_W-1:0]];
            end
            REG_OUTPUT: begin
                cur_bit  = out_bits_reg[head.index[OUT_IDX_W-1:0]];
                prev_bit = prev_out_reg[head.index[OUT_IDX_W-1:0]];
            end
            REG_RELAY: begin
                cur_bit  = relay_reg[head.index[RLY_IDX_W-1:0]];
                prev_bit = prev_relay_reg[head.index[RLY_IDX_W-1:0]];
            end
            default: begin
                cur_bit  = 1'b0;
                prev_bit = 1'b0;
            end
        endcase
    end

    // operand from the addressed bit
    assign edge_code = {cur_bit, prev_bit};
    always_comb begin
        unique case (head.src)
            SRC_PLAIN: operand = cur_bit;
            SRC_NOT:   operand = !cur_bit;
            SRC_RISE:  operand = (edge_code == EDGE_CUR);
            SRC_FALL:  operand = (edge_code == EDGE_PREV);
            default:   operand = cur_bit;
        endcase
    end

    assign sp_dec = sp_reg - SP_W'(1);

    // instruction execution
    always_comb begin
        acc_next        = acc_reg;
        stack_next      = stack_reg;
        sp_next         = sp_reg;
        prev_in_next    = prev_in_reg;
        prev_out_next   = prev_out_reg;
        prev_relay_next = prev_relay_reg;
        wr_en           = 1'b0;
        wr_val          = acc_reg;
        adv             = head.advance;
        restart         = 1'b0;
        err             = ERR_NONE;
        unique case (head.kind)
            K_END: begin
                prev_in_next    = cur_in;
                prev_out_next   = out_bits_reg;
                prev_relay_next = relay_reg;
                restart         = 1'b1;
            end
            K_LOAD: acc_next = operand;
            K_AND:  acc_next = acc_reg & operand;
            K_OR:   acc_next = acc_reg | operand;
            K_OUT:  wr_en = 1'b1;
            K_SET: begin
                wr_en  = acc_reg;
                wr_val = 1'b1;
            end
            K_RST: begin
                wr_en  = acc_reg;
                wr_val = 1'b0;
            end
            K_MPS: begin
                if (sp_reg == SP_W'(STACK_DEPTH)) begin
                    adv     = ADV_RESTART;
                    restart = 1'b1;
                    err     = ERR_OVERFLOW;
                end else begin
                    stack_next[sp_reg[STK_IDX_W-1:0]] = acc_reg;
                    sp_next = sp_reg + SP_W'(1);
                end
            end
            K_MRD, K_MPP: begin
                if (sp_reg == '0) begin
                    adv     = ADV_RESTART;
                    restart = 1'b1;
                    err     = ERR_UNDERFLOW;
                end else begin
                    acc_next = stack_reg[sp_dec[STK_IDX_W-1:0]];
                    if (head.kind == K_MPP) begin
                        sp_next = sp_dec;
                    end
                end
            end
            K_INV:   acc_next = !acc_reg;
            default: acc_next = acc_reg;
        endcase
    end

    // bit write into the output or relay image
    always_comb begin
        out_bits_next = out_bits_reg;
        relay_next    = relay_reg;
        if (wr_en) begin
            unique case (head.region)
                REG_OUTPUT: out_bits_next[head.index[OUT_IDX_W-1:0]] = wr_val;
                REG_RELAY:  relay_next[head.index[RLY_IDX_W-1:0]] = wr_val;
                default:    out_bits_next = out_bits_reg;
            endcase
        end
    end

    // result word built from the updated images
    assign out_ext = OUT_EXT_W'(out_bits_next);
    always_comb begin
        m_data_next = '0;
        m_data_next[IMAGE_W-1:0]                  = out_ext[IMAGE_W-1:0];
        m_data_next[IMAGE_W]                      = acc_next;
        m_data_next[IMAGE_W+1 +: ADV_W]           = adv;
        m_data_next[IMAGE_W+1+ADV_W]              = restart;
        m_data_next[IMAGE_W+2+ADV_W +: ERR_W]     = err;
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= 1'b0;
            stack_reg      <= '0;
            sp_reg         <= '0;
            out_bits_reg   <= '0;
            relay_reg      <= '0;
            prev_in_reg    <= '0;
            prev_out_reg   <= '0;
            prev_relay_reg <= '0;
        end else if (pop) begin
            acc_reg        <= acc_next;
            stack_reg      <= stack_next;
            sp_reg         <= sp_next;
            out_bits_reg   <= out_bits_next;
            relay_reg      <= relay_next;
            prev_in_reg    <= prev_in_next;
            prev_out_reg   <= prev_out_next;
            prev_relay_reg <= prev_relay_next;
        end
    end

    // result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* tb/plcbl_exec_checker.sv */
// checker for the plc bit logic executor: instruction predictor and result comparison
`timescale 1ns / 1ps

module plcbl_exec_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [plcbl_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [plcbl_pkg::M_DATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             pending_words
);
    import plcbl_pkg::*;

    // one predicted result word
    typedef struct packed {
        logic [IMAGE_W-1:0] out_img;
        logic               acc;
        logic [ADV_W-1:0]   adv;
        logic               restart;
        logic [ERR_W-1:0]   err;
    } exec_result_t;

    // predicted machine state
    logic                    acc_q;
    logic [STACK_DEPTH-1:0]  branch_bits;
    int unsigned             depth;
    logic [OUTPUT_COUNT-1:0] out_bits;
    logic [OUTPUT_COUNT-1:0] prev_out_bits;
    logic [RELAY_COUNT-1:0]  relay_img;
    logic [RELAY_COUNT-1:0]  prev_relay_img;
    logic [INPUT_COUNT-1:0]  cur_in_bits;
    logic [INPUT_COUNT-1:0]  prev_in_bits;

    exec_result_t expected_results[$];
    int           fails = 0;

    // read one bit of the current or previous-scan space
    function automatic logic space_bit(input int unsigned a, input bit prev);
        if (a < OUT_BASE)
            return prev ? prev_in_bits[a] : cur_in_bits[a];
        if (a < RELAY_BASE)
            return prev ? prev_out_bits[a - OUT_BASE] : out_bits[a - OUT_BASE];
        if (a < SPACE_END)
            return prev ? prev_relay_img[a - RELAY_BASE] : relay_img[a - RELAY_BASE];
        return 1'b0;
    endfunction

    // inputs and unmapped addresses are not writable
    function automatic void write_space(input int unsigned a, input logic v);
        if (a >= OUT_BASE && a < RELAY_BASE)
            out_bits[a - OUT_BASE] = v;
        else if (a >= RELAY_BASE && a < SPACE_END)
            relay_img[a - RELAY_BASE] = v;
    endfunction

    // run one instruction word against the predicted state
    function automatic exec_result_t execute_instruction(input logic [S_DATA_W-1:0] w);
        logic [OPCODE_W-1:0] op;
        int unsigned         a;
        logic [1:0]          edge_bits;
        logic                b;
        exec_result_t        r;
        op = w[OPCODE_W-1:0];
        a = w[OPCODE_W +: ADDR_W];
        cur_in_bits = w[OPCODE_W + ADDR_W +: IMAGE_W];
        r.adv = ADV_LONG;
        r.restart = 1'b0;
        r.err = ERR_NONE;
        case (op)
            OP_END: begin
                prev_in_bits = cur_in_bits;
                prev_out_bits = out_bits;
                prev_relay_img = relay_img;
                r.adv = ADV_RESTART;
                r.restart = 1'b1;
            end
            OP_LD:  acc_q = space_bit(a, 1'b0);
            OP_LDI: acc_q = ~space_bit(a, 1'b0);
            OP_OUT: write_space(a, acc_q);
            OP_AND: acc_q = acc_q & space_bit(a, 1'b0);
            OP_ANI: acc_q = acc_q & ~space_bit(a, 1'b0);
            OP_OR:  acc_q = acc_q | space_bit(a, 1'b0);
            OP_ORI: acc_q = acc_q | ~space_bit(a, 1'b0);
            OP_LDP, OP_LDF, OP_ANDP, OP_ANDF, OP_ORP, OP_ORF: begin
                // current bit in the upper position, previous-scan bit below
                edge_bits = {space_bit(a, 1'b0), space_bit(a, 1'b1)};
                if (op == OP_LDP || op == OP_ANDP || op == OP_ORP)
                    b = (edge_bits == EDGE_CUR);
                else
                    b = (edge_bits == EDGE_PREV);
                if (op == OP_LDP || op == OP_LDF)
                    acc_q = b;
                else if (op == OP_ANDP || op == OP_ANDF)
                    acc_q = acc_q & b;
                else
                    acc_q = acc_q | b;
            end
            OP_MPS: begin
                r.adv = ADV_SHORT;
                if (depth >= STACK_DEPTH) begin
                    r.adv = ADV_RESTART;
                    r.restart = 1'b1;
                    r.err = ERR_OVERFLOW;
                end else begin
                    branch_bits[depth] = acc_q;
                    depth++;
                end
            end
            OP_MRD, OP_MPP: begin
                r.adv = ADV_SHORT;
                if (depth == 0) begin
                    r.adv = ADV_RESTART;
                    r.restart = 1'b1;
                    r.err = ERR_UNDERFLOW;
                end else begin
                    acc_q = branch_bits[depth - 1];
                    if (op == OP_MPP)
                        depth--;
                end
            end
            OP_SET: if (acc_q) write_space(a, 1'b1);
            OP_RST: if (acc_q) write_space(a, 1'b0);
            OP_INV: begin
                acc_q = ~acc_q;
                r.adv = ADV_SHORT;
            end
            // nop and unused codes
            default: r.adv = ADV_SHORT;
        endcase
        r.out_img = out_bits[IMAGE_W-1:0];
        r.acc = acc_q;
        return r;
    endfunction

    function automatic int field_bad(input string name, input int unsigned want,
                                     input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // sample both channels at the clock edge
    always @(posedge aclk) begin
        exec_result_t want;
        if (!aresetn) begin
            acc_q = 1'b0;
            branch_bits = '0;
            depth = 0;
            out_bits = '0;
            prev_out_bits = '0;
            relay_img = '0;
            prev_relay_img = '0;
            cur_in_bits = '0;
            prev_in_bits = '0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(execute_instruction(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result word %h with no instruction pending", m_tdata);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    fails += field_bad("output_image", want.out_img, m_tdata[15:0]);
                    fails += field_bad("accumulator", want.acc, m_tdata[16]);
                    fails += field_bad("advance", want.adv, m_tdata[18:17]);
                    fails += field_bad("restart_scan", want.restart, m_tdata[19]);
                    fails += field_bad("error_code", want.err, m_tdata[21:20]);
                end
            end
        end
        fail_count <= fails;
        pending_words <= expected_results.size();
    end

endmodule

/* tb/tb_plc_bit_logic_executor.sv */
// testbench top for the plc bit logic executor: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_plc_bit_logic_executor;
    import plcbl_pkg::*;

    localparam int RANDOM_WORDS = 1450;
    localparam int HOLD_CYCLES = 120;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_TOP = 5'd31;

    // one step of a generated rung program
    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [ADDR_W-1:0]   addr;
    } rung_step_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                rx_ready = 1'b0;
    logic                rx_hold = 1'b0;

    int                  fail_count;
    int                  pending_words;
    int                  words_sent = 0;
    bit                  quiet = 1'b0;
    logic [IMAGE_W-1:0]  field_inputs = '0;

    assign m_tready = rx_ready & ~rx_hold;

    always #5 aclk = ~aclk;

    plc_bit_logic_executor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    plcbl_exec_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // offer one instruction word after a random gap and wait for acceptance
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [IMAGE_W-1:0] img);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W - OPCODE_W - ADDR_W - IMAGE_W){1'b0}}, img, addr, op};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // mostly mapped addresses, some just past the relays, some anywhere
    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return ADDR_W'($urandom_range(0, SPACE_END - 1));
        if (r < 95)
            return ADDR_W'($urandom_range(SPACE_END, SPACE_END + 40));
        return ADDR_W'($urandom);
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_load();
        case ($urandom_range(0, 3))
            0: return OP_LD;
            1: return OP_LDI;
            2: return OP_LDP;
            default: return OP_LDF;
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_combine();
        case ($urandom_range(0, 7))
            0: return OP_AND;
            1: return OP_ANI;
            2: return OP_OR;
            3: return OP_ORI;
            4: return OP_ANDP;
            5: return OP_ANDF;
            6: return OP_ORP;
            default: return OP_ORF;
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_write();
        case ($urandom_range(0, 2))
            0: return OP_OUT;
            1: return OP_SET;
            default: return OP_RST;
        endcase
    endfunction

    // build a balanced rung program over a small address pool and run several scans
    task automatic run_program();
        rung_step_t          prog[$];
        rung_step_t          st;
        logic [ADDR_W-1:0]   pool[6];
        int                  len;
        int                  nest;
        int                  k;
        int                  scans;
        pool[0] = ADDR_W'($urandom_range(0, INPUT_COUNT - 1));
        pool[1] = ADDR_W'($urandom_range(0, INPUT_COUNT - 1));
        pool[2] = ADDR_W'($urandom_range(OUT_BASE, RELAY_BASE - 1));
        pool[3] = ADDR_W'($urandom_range(OUT_BASE, RELAY_BASE - 1));
        pool[4] = ADDR_W'($urandom_range(RELAY_BASE, SPACE_END - 1));
        pool[5] = ($urandom_range(0, 3) == 0) ? pick_address()
                      : ADDR_W'($urandom_range(RELAY_BASE, SPACE_END - 1));
        len = $urandom_range(6, 20);
        nest = 0;
        for (int i = 0; i < len; i++) begin
            k = $urandom_range(0, 99);
            st.addr = pool[$urandom_range(0, 5)];
            if (k < 15)
                st.op = pick_load();
            else if (k < 45)
                st.op = pick_combine();
            else if (k < 65)
                st.op = pick_write();
            else if (k < 72 && nest < 8) begin
                st.op = OP_MPS;
                nest++;
            end else if (k >= 72 && k < 78 && nest > 0)
                st.op = OP_MRD;
            else if (k >= 78 && k < 84 && nest > 0) begin
                st.op = OP_MPP;
                nest--;
            end else if (k < 92)
                st.op = OP_INV;
            else
                st.op = OP_NOP;
            if (st.op inside {OP_MPS, OP_MRD, OP_MPP, OP_INV, OP_NOP})
                st.addr = pick_address();
            prog.push_back(st);
        end
        while (nest > 0) begin
            st.op = OP_MPP;
            st.addr = pick_address();
            prog.push_back(st);
            nest--;
        end
        scans = $urandom_range(3, 8);
        repeat (scans) begin
            // a few inputs change between scans so edges show up both ways
            repeat ($urandom_range(0, 3))
                field_inputs[$urandom_range(0, IMAGE_W - 1)] ^= 1'b1;
            foreach (prog[i])
                send_word(prog[i].op, prog[i].addr, field_inputs);
            send_word(OP_END, pick_address(), field_inputs);
        end
    endtask

    // fill the branch stack past its depth, then send more MRD and MPP words than its depth
    task automatic stack_burst();
        repeat (STACK_DEPTH + $urandom_range(1, 2)) begin
            send_word(OP_MPS, pick_address(), IMAGE_W'($urandom));
            if ($urandom_range(0, 2) == 0)
                send_word(OP_INV, pick_address(), IMAGE_W'($urandom));
        end
        repeat (STACK_DEPTH + $urandom_range(1, 2))
            send_word(($urandom_range(0, 3) == 0) ? OP_MRD : OP_MPP, pick_address(),
                      IMAGE_W'($urandom));
    endtask

    // result side: random stall before each word
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                rx_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            rx_ready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // long hold-off on the result side so the block backs up its input
    initial begin
        while (words_sent < 300) @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int k;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        send_word(OP_NOP, 16'h0000, 16'h0000);
        send_word(OP_LD, 16'd0, 16'h0001);
        send_word(OP_OUT, ADDR_W'(OUT_BASE), 16'h0001);
        send_word(OP_SET, ADDR_W'(SPACE_END - 1), 16'h0000);
        send_word(OP_LDI, ADDR_W'(SPACE_END - 1), 16'h0000);
        send_word(OP_LD, ADDR_W'(SPACE_END - 1), 16'h0000);
        send_word(OP_OUT, ADDR_W'(INPUT_COUNT - 1), 16'h0000);
        send_word(OP_OUT, ADDR_W'(SPACE_END), 16'h0000);
        send_word(OP_AND, ADDR_W'(SPACE_END + 20), 16'hFFFF);
        send_word(OP_ORI, ADDR_W'(RELAY_BASE - 1), 16'h0000);
        send_word(OP_OUT, ADDR_W'(RELAY_BASE - 1), 16'h0000);
        send_word(OP_ANI, 16'hFFFF, 16'hFFFF);
        send_word(OP_RST, ADDR_W'(OUT_BASE), 16'h0000);
        send_word(OP_INV, 16'h0000, 16'h0000);
        send_word(OP_SET, ADDR_W'(OUT_BASE + 4), 16'h0000);
        send_word(OP_RST, ADDR_W'(RELAY_BASE - 1), 16'h0000);
        send_word(OP_OR, ADDR_W'(INPUT_COUNT - 1), 16'h8000);
        send_word(OP_END, 16'h0000, 16'hFFFF);
        send_word(OP_LDP, ADDR_W'(INPUT_COUNT - 1), 16'h7FFF);
        send_word(OP_LDF, ADDR_W'(INPUT_COUNT - 1), 16'h7FFF);
        send_word(OP_ANDP, ADDR_W'(RELAY_BASE - 1), 16'h7FFF);
        send_word(OP_ORF, ADDR_W'(SPACE_END - 1), 16'h7FFF);
        send_word(OP_MRD, 16'h0000, 16'h0000);
        send_word(OP_MPP, 16'h0000, 16'h0000);
        send_word(OP_MPS, 16'h0000, 16'h0000);
        send_word(OP_MPP, 16'h0000, 16'h0000);
        send_word(OP_UNUSED_TOP, 16'hFFFF, 16'hFFFF);

        // random part: rung programs, noise and stack bursts
        while (words_sent < RANDOM_WORDS) begin
            quiet = ($urandom_range(0, 5) == 0);
            k = $urandom_range(0, 99);
            if (k < 75)
                run_program();
            else if (k < 93) begin
                repeat ($urandom_range(1, 10))
                    send_word(OPCODE_W'($urandom_range(0, 31)), pick_address(),
                              IMAGE_W'($urandom));
            end else
                stack_burst();
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
